FILE: design/gmrb_pkg.sv
// Shared types, widths and codes for the gyro mouse report builder.
// No dependencies; imported by every module of the block.
package gmrb_pkg;

   // Averaging window and field widths
   localparam int WINDOW_LEN = 3;
   localparam int RATE_W     = 16;
   localparam int SAMPLE_W   = RATE_W + 1;
   localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN);
   localparam int DIV_W      = 16;
   localparam int MOVE_W     = 8;
   localparam int BTN_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic signed [RATE_W-1:0] OFFSET_RESET = 16'sd12;
   localparam logic [DIV_W-1:0]         SCALE_RESET  = 16'd23;
   localparam logic [DIV_W-1:0]         DEAD_RESET   = 16'd2;

   // Button report codes
   localparam logic [BTN_W-1:0] BTN_RELEASED = 2'd0;
   localparam logic [BTN_W-1:0] BTN_ONE      = 2'd1;
   localparam logic [BTN_W-1:0] BTN_TWO      = 2'd2;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_X = 2'd0,
      CSR_OFFSET_Z = 2'd1,
      CSR_SCALE    = 2'd2,
      CSR_DEAD     = 2'd3
   } csr_reg_type;

   // Per-axis settings handed from the register file to an axis
   typedef struct packed {
      logic signed [RATE_W-1:0] offset;
      logic [DIV_W-1:0]         scale_divisor;
      logic [DIV_W-1:0]         dead_zone;
   } axis_cfg_type;

endpackage

FILE: design/gmrb_serdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on gmrb_pkg for SUM_W and DIV_W.
module gmrb_serdiv import gmrb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(SUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dvsr_ff, dvsr_in;
   logic [DIV_W:0]   rem_shift;
   logic             fits;

   // Shift in the next dividend bit and trial-subtract the divisor
   always_comb begin
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      fits      = rem_shift >= {1'b0, dvsr_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvsr_in   = dvsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         dvsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? DIV_W'(rem_shift - {1'b0, dvsr_ff}) : DIV_W'(rem_shift);
         quo_in   = {quo_ff[SUM_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: design/gmrb_axis.sv
// One gyro axis: offset, sliding window with running sum, averaging and
// scaling through a serial divider, dead zone, negation to 8 bits.
// Depends on gmrb_pkg and gmrb_serdiv.
module gmrb_axis import gmrb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [RATE_W-1:0] rate,
   input  axis_cfg_type             cfg,
   output logic                     done,
   output logic [MOVE_W-1:0]        move
);

   typedef enum logic [1:0] {AX_IDLE, AX_SUM, AX_AVG, AX_SCALE} axis_state_type;

   axis_state_type             state_ff, state_in;
   logic signed [SAMPLE_W-1:0] window_ff [WINDOW_LEN];
   logic signed [SAMPLE_W-1:0] window_in [WINDOW_LEN];
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic                       neg_ff, neg_in;
   logic [MOVE_W-1:0]          move_ff, move_in;
   logic                       done_ff, done_in;

   logic signed [SAMPLE_W-1:0] sample;
   logic [SUM_W-1:0]           sum_mag;
   logic [DIV_W-1:0]           scale_eff;
   logic                       in_dead;
   logic [MOVE_W-1:0]          quo_low;
   logic                       div_start;
   logic [SUM_W-1:0]           div_dividend;
   logic [DIV_W-1:0]           div_divisor;
   logic                       div_done;
   logic [SUM_W-1:0]           div_quo;

   gmrb_serdiv u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Calibrated sample, magnitude of the window sum, effective divisor
   assign sample    = SAMPLE_W'(rate) + SAMPLE_W'(cfg.offset);
   assign sum_mag   = sum_ff[SUM_W-1] ? $unsigned(-sum_ff) : $unsigned(sum_ff);
   assign scale_eff = (cfg.scale_divisor == '0) ? DIV_W'(1) : cfg.scale_divisor;
   assign in_dead   = div_quo < SUM_W'(cfg.dead_zone);
   assign quo_low   = div_quo[MOVE_W-1:0];

   // Sequence: update window, divide by window length, divide by scale
   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      sum_in       = sum_ff;
      neg_in       = neg_ff;
      move_in      = move_ff;
      done_in      = 1'b0;
      div_start    = 1'b0;
      div_dividend = sum_mag;
      div_divisor  = DIV_W'(WINDOW_LEN);
      unique case (state_ff)
         AX_IDLE: begin
            if (start) begin
               for (int k = 0; k < WINDOW_LEN - 1; k++) begin
                  window_in[k] = window_ff[k + 1];
               end
               window_in[WINDOW_LEN-1] = sample;
               sum_in   = sum_ff + SUM_W'(sample) - SUM_W'(window_ff[0]);
               state_in = AX_SUM;
            end
         end
         AX_SUM: begin
            neg_in    = sum_ff[SUM_W-1];
            div_start = 1'b1;
            state_in  = AX_AVG;
         end
         AX_AVG: begin
            div_dividend = div_quo;
            div_divisor  = scale_eff;
            if (div_done) begin
               div_start = 1'b1;
               state_in  = AX_SCALE;
            end
         end
         AX_SCALE: begin
            if (div_done) begin
               // Quotient sign follows the sum; the report is its negation
               if (in_dead) begin
                  move_in = '0;
               end else if (neg_ff) begin
                  move_in = quo_low;
               end else begin
                  move_in = MOVE_W'(0) - quo_low;
               end
               done_in  = 1'b1;
               state_in = AX_IDLE;
            end
         end
         default: state_in = AX_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AX_IDLE;
         for (int k = 0; k < WINDOW_LEN; k++) begin
            window_ff[k] <= '0;
         end
         sum_ff  <= '0;
         neg_ff  <= 1'b0;
         move_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         window_ff <= window_in;
         sum_ff    <= sum_in;
         neg_ff    <= neg_in;
         move_ff   <= move_in;
         done_ff   <= done_in;
      end
   end

   assign done = done_ff;
   assign move = move_ff;

endmodule

FILE: design/gyro_mouse_report_builder_unit.sv
// A request carrying a gyro sample keeps the input closed from its transfer until
// its result moves from the pending flag into the output register. Each axis runs two
// 19-step bit-serial divisions back to back (window average, then scaling) in its
// own divider, and both axes work in parallel. Besides the divisions, the sequence
// holds the window update, the two division starts, the move register, the pending
// flag and the output load, which happens once the output register is free. A
// request with no sample but a button edge sets the pending flag, and its report is
// loaded from there like any other; one with neither produces none. The report sits in
// an output register, so the next request is taken while it waits for the consumer.
// A finished result that finds the output register still full holds the input
// closed until the consumer takes the older report. Settings are written through
// the csr_ port with no wait; write them only while the block is idle.
// Depends on gmrb_pkg and gmrb_axis.
module gyro_mouse_report_builder_unit import gmrb_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_sample_present,
   input  logic signed [RATE_W-1:0]     req_rate_x,
   input  logic signed [RATE_W-1:0]     req_rate_z,
   input  logic                         req_left_level,
   input  logic                         req_right_level,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [MOVE_W-1:0]     rsp_move_horiz,
   output logic signed [MOVE_W-1:0]     rsp_move_vert,
   output logic [BTN_W-1:0]             rsp_button_code,
   input  logic                         csr_write_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data
);

   logic signed [RATE_W-1:0] offset_x_ff, offset_z_ff;
   logic [DIV_W-1:0]         scale_ff, dead_ff;

   logic              busy_ff, busy_in;
   logic              pend_ff, pend_in;
   logic              left_prev_ff, left_prev_in;
   logic              right_prev_ff, right_prev_in;
   logic [BTN_W-1:0]  held_btn_ff, held_btn_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MOVE_W-1:0] rsp_horiz_ff, rsp_horiz_in;
   logic [MOVE_W-1:0] rsp_vert_ff, rsp_vert_in;
   logic [BTN_W-1:0]  rsp_btn_ff, rsp_btn_in;

   logic              accept;
   logic              start;
   logic              load;
   logic              left_edge;
   logic              right_edge;
   axis_cfg_type      cfg_x, cfg_z;
   logic              x_done, z_done;
   logic [MOVE_W-1:0] x_move, z_move;

   // Register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= OFFSET_RESET;
         offset_z_ff <= OFFSET_RESET;
         scale_ff    <= SCALE_RESET;
         dead_ff     <= DEAD_RESET;
      end else if (csr_write_en) begin
         unique case (csr_reg_type'(csr_index))
            CSR_OFFSET_X: offset_x_ff <= RATE_W'(csr_write_data);
            CSR_OFFSET_Z: offset_z_ff <= RATE_W'(csr_write_data);
            CSR_SCALE:    scale_ff    <= DIV_W'(csr_write_data);
            CSR_DEAD:     dead_ff     <= DIV_W'(csr_write_data);
            default: ;
         endcase
      end
   end

   assign cfg_x = '{offset: offset_x_ff, scale_divisor: scale_ff, dead_zone: dead_ff};
   assign cfg_z = '{offset: offset_z_ff, scale_divisor: scale_ff, dead_zone: dead_ff};

   // Vertical movement from x, horizontal from z
   gmrb_axis u_axis_x (
      .clock (clock),
      .reset (reset),
      .start (start),
      .rate  (req_rate_x),
      .cfg   (cfg_x),
      .done  (x_done),
      .move  (x_move)
   );

   gmrb_axis u_axis_z (
      .clock (clock),
      .reset (reset),
      .start (start),
      .rate  (req_rate_z),
      .cfg   (cfg_z),
      .done  (z_done),
      .move  (z_move)
   );

   assign req_ready  = !busy_ff && !pend_ff;
   assign accept     = req_valid && req_ready;
   assign start      = accept && req_sample_present;
   assign load       = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign left_edge  = req_left_level != left_prev_ff;
   assign right_edge = req_right_level != right_prev_ff;

   // Track buttons, sequence the axes and fill the output register
   always_comb begin
      busy_in       = busy_ff;
      pend_in       = pend_ff;
      left_prev_in  = left_prev_ff;
      right_prev_in = right_prev_ff;
      held_btn_in   = held_btn_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_horiz_in  = rsp_horiz_ff;
      rsp_vert_in   = rsp_vert_ff;
      rsp_btn_in    = rsp_btn_ff;
      if (accept) begin
         left_prev_in  = req_left_level;
         right_prev_in = req_right_level;
         // Right button is handled last, so it wins when both change
         if (left_edge) begin
            held_btn_in = req_left_level ? BTN_TWO : BTN_RELEASED;
         end
         if (right_edge) begin
            held_btn_in = req_right_level ? BTN_ONE : BTN_RELEASED;
         end
         if (req_sample_present) begin
            busy_in = 1'b1;
         end else if (left_edge || right_edge) begin
            pend_in = 1'b1;
         end
      end
      if (busy_ff && x_done) begin
         busy_in = 1'b0;
         pend_in = 1'b1;
      end
      if (load) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_horiz_in = z_move;
         rsp_vert_in  = x_move;
         rsp_btn_in   = held_btn_ff;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         left_prev_ff  <= 1'b0;
         right_prev_ff <= 1'b0;
         held_btn_ff   <= BTN_RELEASED;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         pend_ff       <= pend_in;
         left_prev_ff  <= left_prev_in;
         right_prev_ff <= right_prev_in;
         held_btn_ff   <= held_btn_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_horiz_ff <= rsp_horiz_in;
      rsp_vert_ff  <= rsp_vert_in;
      rsp_btn_ff   <= rsp_btn_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_move_horiz  = rsp_horiz_ff;
   assign rsp_move_vert   = rsp_vert_ff;
   assign rsp_button_code = rsp_btn_ff;

`ifndef SYNTHESIS
   // Both axes run in lockstep
   a_axes_lockstep: assert property (@(posedge clock) disable iff (reset)
      x_done == z_done)
      else $error("axis completions out of step");

   // An axis only finishes while a sample is in flight
   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      x_done |-> busy_ff)
      else $error("axis completion with no sample in flight");

   // A pending report never overlaps axis work
   a_busy_pend_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && pend_ff))
      else $error("pending report while axes busy");

   // A new report appears only from a pending one
   a_rsp_from_pend: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pend_ff))
      else $error("report raised without a pending result");
`endif

endmodule
